### rtl/fft_pkg.sv
package fft_pkg;
	localparam int POINTS = 64;
	localparam int AW = $clog2(POINTS);
	localparam int SW = $clog2(AW + 1);
	localparam int DW = 24;
	localparam int TW = 16;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam logic signed [DW-1:0] MAG_MAX = 24'sh7FFFFF;
	localparam logic signed [DW-1:0] MAG_MIN = -24'sh800000;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
	} cplx_t;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               inv;
	} qitem_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_BF_RD, ST_BF_A, ST_BF_B, ST_BF_MUL, ST_BF_WR, ST_EMIT_RD, ST_EMIT_OUT
	} state_t;

	// round(32768*cos(pi*k/32)), +1.0 saturated
	function automatic logic signed [TW-1:0] qcos(input logic [4:0] k);
		logic signed [TW-1:0] v;
		case (k)
			5'd0: v = 16'sd32767;
			5'd1: v = 16'sd32610;
			5'd2: v = 16'sd32138;
			5'd3: v = 16'sd31357;
			5'd4: v = 16'sd30274;
			5'd5: v = 16'sd28899;
			5'd6: v = 16'sd27246;
			5'd7: v = 16'sd25330;
			5'd8: v = 16'sd23170;
			5'd9: v = 16'sd20788;
			5'd10: v = 16'sd18205;
			5'd11: v = 16'sd15447;
			5'd12: v = 16'sd12540;
			5'd13: v = 16'sd9512;
			5'd14: v = 16'sd6393;
			5'd15: v = 16'sd3212;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// twiddle for table index j (0..31) scaled to POINTS
	function automatic logic signed [2*TW-1:0] twiddle(input logic [4:0] j);
		logic [4:0] kk;
		logic signed [TW-1:0] c, s;
		kk = 5'((int'(j) * (64 / POINTS)) & 31);
		if (kk <= 5'd16) begin
			c = qcos(kk);
			s = qcos(5'(5'd16 - kk));
		end else begin
			c = -qcos(5'(6'd32 - {1'b0, kk}));
			s = qcos(5'(kk - 5'd16));
		end
		return {c, s};
	endfunction

	function automatic logic signed [DW-1:0] sat24(input logic signed [47:0] v);
		logic signed [DW-1:0] r;
		if (v > 48'(MAG_MAX)) r = MAG_MAX;
		else if (v < 48'(MAG_MIN)) r = MAG_MIN;
		else r = v[DW-1:0];
		return r;
	endfunction
endpackage

### rtl/fft_front.sv
module fft_front import fft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	input  logic              inv,
	output logic              q_valid,
	input  logic              q_pop,
	output qitem_t            q_item
);
	qitem_t mem_q [QDEPTH];
	logic [QAW:0] wp_q, rp_q;
	logic push;

	assign ready   = (wp_q - rp_q) != (QAW+1)'(QDEPTH);
	assign push    = valid && ready;
	assign q_valid = wp_q != rp_q;
	assign q_item  = mem_q[rp_q[QAW-1:0]];

	// store the sample with the inverse flag seen at transfer
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q[QAW-1:0]] <= '{re: sample_re, im: sample_im, inv: inv};
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop && q_valid) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

### rtl/fft_back.sv
module fft_back import fft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  qitem_t            q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [DW-1:0] result_re,
	output logic signed [DW-1:0] result_im,
	output logic              result_last
);
	cplx_t ping [POINTS];
	cplx_t pong [POINTS];
	state_t st_q, st_d;
	logic [AW:0] cnt_q;
	logic [AW-1:0] k_q;
	logic [SW-1:0] stage_q;
	logic src_pong_q, inv_q;
	logic [AW-1:0] ra, rb, wc, wd, jm;
	cplx_t a_q, sum_q;
	cplx_t rdp_q;
	logic signed [DW:0] dr_q, di_q;
	logic signed [TW-1:0] wr_q, wi_q;
	logic signed [47:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [47:0] nr, ni;
	logic signed [DW-1:0] ore_q, oim_q;
	logic olast_q, oval_q;
	logic [AW-1:0] mj, rdaddr;
	logic wr_en, out_load;
	cplx_t wdata0, wdata1;
	logic [2*TW-1:0] tw;

	// butterfly addressing: mj = 2^stage, jm = j*mj
	assign mj = AW'(1) << stage_q;
	assign jm = k_q & ~(mj - 1'b1);
	assign ra = k_q;
	assign rb = k_q + AW'(POINTS/2);
	assign wc = AW'({jm, 1'b0}) + (k_q & (mj - 1'b1));
	assign wd = wc + mj;
	assign tw = twiddle(5'(jm));
	assign rdaddr = (st_q == ST_BF_RD) ? ra : rb;

	// read port: source buffer, one address per cycle; hold the bin address while emitting
	always_ff @(posedge clk) begin
		if (src_pong_q)
			rdp_q <= pong[(st_q == ST_EMIT_RD || st_q == ST_EMIT_OUT) ? k_q : rdaddr];
		else
			rdp_q <= ping[(st_q == ST_EMIT_RD || st_q == ST_EMIT_OUT) ? k_q : rdaddr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_BF_A: a_q <= rdp_q;
			ST_BF_B: begin
				sum_q.re <= sat24(48'(a_q.re) + 48'(rdp_q.re));
				sum_q.im <= sat24(48'(a_q.im) + 48'(rdp_q.im));
				dr_q <= (DW+1)'(a_q.re) - (DW+1)'(rdp_q.re);
				di_q <= (DW+1)'(a_q.im) - (DW+1)'(rdp_q.im);
				wr_q <= tw[2*TW-1:TW];
				wi_q <= inv_q ? -tw[TW-1:0] : tw[TW-1:0];
			end
			ST_BF_MUL: begin
				p0_q <= 48'(wr_q) * 48'(dr_q);
				p1_q <= 48'(wi_q) * 48'(di_q);
				p2_q <= 48'(wi_q) * 48'(dr_q);
				p3_q <= 48'(wr_q) * 48'(di_q);
			end
			default: ;
		endcase
	end

	assign nr = (p0_q - p1_q + 48'sd16384) >>> 15;
	assign ni = (p2_q + p3_q + 48'sd16384) >>> 15;
	assign wdata0 = sum_q;
	assign wdata1 = '{re: sat24(nr), im: sat24(ni)};
	assign wr_en = (st_q == ST_BF_WR);

	// write port: load into ping, butterflies into the other buffer (two writes)
	always_ff @(posedge clk) begin
		if (st_q == ST_LOAD && q_valid)
			ping[cnt_q[AW-1:0]] <= '{re: DW'(q_item.re), im: DW'(q_item.im)};
		else if (wr_en && src_pong_q) begin
			ping[wc] <= wdata0;
			ping[wd] <= wdata1;
		end
		if (wr_en && !src_pong_q) begin
			pong[wc] <= wdata0;
			pong[wd] <= wdata1;
		end
	end

	assign out_load = (st_q == ST_EMIT_OUT) && (!oval_q || out_ready);
	assign q_pop = (st_q == ST_LOAD);

	// sequencer
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:   if (q_valid && cnt_q == (AW+1)'(POINTS-1)) st_d = ST_BF_RD;
			ST_BF_RD:  st_d = ST_BF_A;
			ST_BF_A:   st_d = ST_BF_B;
			ST_BF_B:   st_d = ST_BF_MUL;
			ST_BF_MUL: st_d = ST_BF_WR;
			ST_BF_WR:  st_d = (k_q == AW'(POINTS/2-1) && stage_q == SW'(AW-1))
				? ST_EMIT_RD : ST_BF_RD;
			ST_EMIT_RD:  st_d = ST_EMIT_OUT;
			ST_EMIT_OUT: if (out_load) st_d = (k_q == AW'(POINTS-1)) ? ST_LOAD : ST_EMIT_RD;
			default: st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			k_q <= '0;
			stage_q <= '0;
			src_pong_q <= 1'b0;
			inv_q <= 1'b0;
			oval_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			case (st_q)
				ST_LOAD: if (q_valid) begin
					inv_q <= q_item.inv;
					cnt_q <= (cnt_q == (AW+1)'(POINTS-1)) ? '0 : cnt_q + 1'b1;
					k_q <= '0;
					stage_q <= '0;
					src_pong_q <= 1'b0;
				end
				ST_BF_WR: begin
					k_q <= (k_q == AW'(POINTS/2-1)) ? '0 : k_q + 1'b1;
					if (k_q == AW'(POINTS/2-1)) begin
						stage_q <= stage_q + 1'b1;
						src_pong_q <= !src_pong_q;
					end
				end
				ST_EMIT_OUT: if (out_load) begin
					k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			ore_q <= rdp_q.re;
			oim_q <= rdp_q.im;
			olast_q <= (k_q == AW'(POINTS-1));
		end
	end

	assign out_valid = oval_q;
	assign result_re = ore_q;
	assign result_im = oim_q;
	assign result_last = olast_q;
endmodule

### rtl/radix2_stockham_fft_top.sv
// channel | signals                         | direction
// input   | valid, ready, sample_re/_im     | in
// output  | out_valid, out_ready, result_*  | out
// config  | cfg_we, cfg_data (inverse)      | in
// Loading moves queued samples into the ping buffer; each stage then runs POINTS/2
// butterflies (read, A, B, multiply, write states) through the single buffer read port,
// and the bins go out through the read and output states; the four-entry queue keeps
// taking samples, until full, while the back end computes or emits.
// Reset clears the sequencer, queue pointers and inverse; buffers hold no reset.
// A stalled output holds the current bin; the sequencer waits on it.
module radix2_stockham_fft_top import fft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic signed [15:0] sample_re,
	input  logic signed [15:0] sample_im,
	input  logic              cfg_we,
	input  logic              cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [DW-1:0] result_re,
	output logic signed [DW-1:0] result_im,
	output logic              result_last
);
	logic inv_q, q_valid, q_pop;
	qitem_t q_item;

	// hold inverse register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_q <= 1'b0;
		else if (cfg_we) inv_q <= cfg_data;
	end

	fft_front u_front (
		.clk, .arst_n, .valid, .ready, .sample_re, .sample_im,
		.inv(inv_q), .q_valid, .q_pop, .q_item
	);

	fft_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_ready,
		.result_re, .result_im, .result_last
	);

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_re) && $stable(result_last))
		else $error("output changed while stalled");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("input dropped while stalled");
`endif
endmodule
